/* rtl/core/dpa_pkg.sv */
// Package for the data-processing ALU: request and response payloads,
// inter-stage structs, opcode and shift-type codes.
// No dependencies.
package dpa_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_R5  = 4'd5,
      OP_R6  = 4'd6,
      OP_R7  = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_R11 = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_R14 = 4'd14,
      OP_R15 = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic [31:0] instr;
      logic [31:0] rn_value;
      logic [31:0] rm_value;
      logic [31:0] rs_value;
      logic        carry_in;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic [3:0]  dest_index;
      logic        write_back;
      logic        flags_update;
      logic        neg_flag;
      logic        zero_flag;
      logic        carry_out;
      logic        invalid_opcode;
   } rsp_type;

   // Decoded request, ready for the shifter.
   typedef struct packed {
      opcode_type     opcode;
      logic           sbit;
      logic [3:0]     rd;
      logic [31:0]    rn;
      logic [31:0]    sh_val;
      logic [7:0]     sh_amt;
      shift_kind_type sh_kind;
      logic           cin;
   } dec_type;

   // Operand 2 and the shifter carry.
   typedef struct packed {
      opcode_type  opcode;
      logic        sbit;
      logic [3:0]  rd;
      logic [31:0] rn;
      logic [31:0] op2;
      logic        shc;
      logic        cin;
   } shf_type;

   // ALU result before flag generation.
   typedef struct packed {
      logic [31:0] res;
      logic        sbit;
      logic [3:0]  rd;
      logic        write;
      logic        invalid;
      logic        c;
      logic        cin;
   } alu_type;

endpackage

/* rtl/core/dpa_decode.sv */
// First pipeline stage: splits the instruction word and selects the shifter
// source, amount and type. Depends on dpa_pkg.
module dpa_decode
   import dpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    out_valid,
   output dec_type out_dec
);

   logic    valid_ff;
   dec_type dec_ff, dec_in;

   always_comb begin
      dec_in.opcode = opcode_type'(in_req.instr[24:21]);
      dec_in.sbit   = in_req.instr[20];
      dec_in.rd     = in_req.instr[15:12];
      dec_in.rn     = in_req.rn_value;
      dec_in.cin    = in_req.carry_in;
      if (in_req.instr[25]) begin
         // Immediate: 8-bit value rotated right by twice the rotate field.
         dec_in.sh_val  = {24'd0, in_req.instr[7:0]};
         dec_in.sh_amt  = {3'd0, in_req.instr[11:8], 1'b0};
         dec_in.sh_kind = SH_ROR;
      end else begin
         dec_in.sh_val  = in_req.rm_value;
         dec_in.sh_amt  = in_req.instr[4] ? in_req.rs_value[7:0]
                                          : {3'd0, in_req.instr[11:7]};
         dec_in.sh_kind = shift_kind_type'(in_req.instr[6:5]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dec_ff <= dec_in;
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

/* rtl/core/dpa_shift.sv */
// Second pipeline stage: barrel shifter producing operand 2 and the shifter
// carry. Depends on dpa_pkg.
module dpa_shift
   import dpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  dec_type in_dec,
   output logic    out_valid,
   output shf_type out_shf
);

   logic        valid_ff;
   shf_type     shf_ff, shf_in;
   logic [4:0]  amt_lo;
   logic        amt_big;
   logic        amt_eq32;
   logic        sign;
   logic [32:0] lsl_w;
   logic [32:0] lsr_w;
   logic [32:0] asr_w;
   logic [63:0] ror_w;

   assign amt_lo   = in_dec.sh_amt[4:0];
   assign amt_big  = (in_dec.sh_amt[7:5] != 3'd0);
   assign amt_eq32 = (in_dec.sh_amt == 8'd32);
   assign sign     = in_dec.sh_val[DATA_W-1];

   // The spare bit beside the LSL, LSR and ASR words catches the last bit shifted out.
   assign lsl_w = {1'b0, in_dec.sh_val} << amt_lo;
   assign lsr_w = {in_dec.sh_val, 1'b0} >> amt_lo;
   assign asr_w = 33'($signed({in_dec.sh_val, 1'b0}) >>> amt_lo);
   assign ror_w = {in_dec.sh_val, in_dec.sh_val} >> amt_lo;

   always_comb begin
      shf_in.opcode = in_dec.opcode;
      shf_in.sbit   = in_dec.sbit;
      shf_in.rd     = in_dec.rd;
      shf_in.rn     = in_dec.rn;
      shf_in.cin    = in_dec.cin;
      shf_in.op2    = in_dec.sh_val;
      shf_in.shc    = in_dec.cin;
      if (in_dec.sh_amt != 8'd0) begin
         unique case (in_dec.sh_kind)
            SH_LSL: begin
               shf_in.op2 = amt_big ? 32'd0 : lsl_w[31:0];
               shf_in.shc = amt_big ? (amt_eq32 & in_dec.sh_val[0]) : lsl_w[32];
            end
            SH_LSR: begin
               shf_in.op2 = amt_big ? 32'd0 : lsr_w[32:1];
               shf_in.shc = amt_big ? (amt_eq32 & sign) : lsr_w[0];
            end
            SH_ASR: begin
               shf_in.op2 = amt_big ? {DATA_W{sign}} : asr_w[32:1];
               shf_in.shc = amt_big ? sign : asr_w[0];
            end
            SH_ROR: begin
               // A multiple of 32 leaves the value as it is; carry is bit 31.
               shf_in.op2 = ror_w[31:0];
               shf_in.shc = ror_w[31];
            end
            default: begin
               shf_in.op2 = in_dec.sh_val;
               shf_in.shc = in_dec.cin;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      shf_ff <= shf_in;
   end

   assign out_valid = valid_ff;
   assign out_shf   = shf_ff;

endmodule

/* rtl/core/dpa_alu.sv */
// Third pipeline stage: logical and arithmetic operations with the adder
// carry or not-borrow. Depends on dpa_pkg.
module dpa_alu
   import dpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  shf_type in_shf,
   output logic    out_valid,
   output alu_type out_alu
);

   logic        valid_ff;
   alu_type     alu_ff, alu_in;
   logic [32:0] add_w;
   logic [32:0] sub_w;
   logic [32:0] rsb_w;

   // Subtraction as addition of the inverse: bit 32 is the not-borrow.
   assign add_w = {1'b0, in_shf.rn} + {1'b0, in_shf.op2};
   assign sub_w = {1'b0, in_shf.rn} + {1'b0, ~in_shf.op2} + 33'd1;
   assign rsb_w = {1'b0, in_shf.op2} + {1'b0, ~in_shf.rn} + 33'd1;

   always_comb begin
      alu_in.sbit    = in_shf.sbit;
      alu_in.rd      = in_shf.rd;
      alu_in.cin     = in_shf.cin;
      alu_in.write   = 1'b1;
      alu_in.invalid = 1'b0;
      alu_in.c       = in_shf.shc;
      alu_in.res     = in_shf.rn;
      unique case (in_shf.opcode)
         OP_AND: alu_in.res = in_shf.rn & in_shf.op2;
         OP_TST: begin
            alu_in.res   = in_shf.rn & in_shf.op2;
            alu_in.write = 1'b0;
         end
         OP_EOR: alu_in.res = in_shf.rn ^ in_shf.op2;
         OP_TEQ: begin
            alu_in.res   = in_shf.rn ^ in_shf.op2;
            alu_in.write = 1'b0;
         end
         OP_ORR: alu_in.res = in_shf.rn | in_shf.op2;
         OP_MOV: alu_in.res = in_shf.op2;
         OP_SUB: begin
            alu_in.res = sub_w[31:0];
            alu_in.c   = sub_w[32];
         end
         OP_CMP: begin
            alu_in.res   = sub_w[31:0];
            alu_in.c     = sub_w[32];
            alu_in.write = 1'b0;
         end
         OP_RSB: begin
            alu_in.res = rsb_w[31:0];
            alu_in.c   = rsb_w[32];
         end
         OP_ADD: begin
            alu_in.res = add_w[31:0];
            alu_in.c   = add_w[32];
         end
         default: begin
            alu_in.res     = in_shf.rn;
            alu_in.invalid = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      alu_ff <= alu_in;
   end

   assign out_valid = valid_ff;
   assign out_alu   = alu_ff;

endmodule

/* rtl/core/data_processing_alu.sv */
// Data-processing ALU: four register stages (decode, shift, ALU, flags).
// A request passes the decode, shift, ALU and flag registers in turn, and the response
// strobe is raised from the last of them.
// Throughput is one request per cycle; busy stays low because no stage stalls.
// Synchronous active-high reset clears the valid bits; payload is not reset.
// The receiver cannot stall: each response is on rsp_item for one cycle only.
module data_processing_alu
   import dpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic    dec_valid;
   dec_type dec;
   logic    shf_valid;
   shf_type shf;
   logic    alu_valid;
   alu_type alu;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign busy = 1'b0;

   dpa_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_req    (req_item),
      .out_valid (dec_valid),
      .out_dec   (dec)
   );

   dpa_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_dec    (dec),
      .out_valid (shf_valid),
      .out_shf   (shf)
   );

   dpa_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shf_valid),
      .in_shf    (shf),
      .out_valid (alu_valid),
      .out_alu   (alu)
   );

   // Flags are only reported when S is set; otherwise C keeps its old value.
   always_comb begin
      rsp_in.result         = alu.res;
      rsp_in.dest_index     = alu.rd;
      rsp_in.write_back     = alu.write;
      rsp_in.flags_update   = alu.sbit;
      rsp_in.neg_flag       = alu.sbit & alu.res[DATA_W-1];
      rsp_in.zero_flag      = alu.sbit & (alu.res == 32'd0);
      rsp_in.carry_out      = alu.sbit ? alu.c : alu.cin;
      rsp_in.invalid_opcode = alu.invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= alu_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##3 rsp_strobe)
      else $error("request did not produce a response four cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 4))
      else $error("response strobe without a matching request");

   a_invalid_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.invalid_opcode |-> rsp_item.write_back)
      else $error("unsupported opcode must write Rn back");

   a_flags_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.flags_update |->
         !rsp_item.neg_flag && !rsp_item.zero_flag)
      else $error("N or Z raised without the S bit");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the data-processing ALU: directed and random
// instruction requests, a built-in predictor and an in-order response check.
// Depends on dpa_pkg and data_processing_alu.
module testbench
   import dpa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   req_type pending_req[$];
   rsp_type expected_rsp[$];

   int sent_count       = 0;
   int total_requests   = 0;
   int checked_count    = 0;
   int mismatch_count   = 0;
   int flags_set_count  = 0;
   int unsupported_count = 0;
   int reg_shift_count  = 0;

   data_processing_alu i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Returns {carry, value}. A zero amount leaves both value and carry alone.
   function automatic logic [32:0] barrel_shift(shift_kind_type kind, logic [31:0] v,
                                                logic [7:0] amt, logic cin);
      logic [31:0] r;
      logic        c;
      logic [4:0]  a;
      if (amt == 8'd0) return {cin, v};
      case (kind)
         SH_LSL: begin
            if (amt < 8'd32) begin
               r = v << amt;
               c = v[32 - amt];
            end else begin
               r = '0;
               c = (amt == 8'd32) ? v[0] : 1'b0;
            end
         end
         SH_LSR: begin
            if (amt < 8'd32) begin
               r = v >> amt;
               c = v[amt - 1];
            end else begin
               r = '0;
               c = (amt == 8'd32) ? v[31] : 1'b0;
            end
         end
         SH_ASR: begin
            if (amt < 8'd32) begin
               r = $unsigned($signed(v) >>> amt);
               c = v[amt - 1];
            end else begin
               r = {32{v[31]}};
               c = v[31];
            end
         end
         default: begin
            // Rotation wraps modulo 32; a whole number of turns keeps the value.
            a = amt[4:0];
            if (a == 5'd0) begin
               r = v;
               c = v[31];
            end else begin
               r = (v >> a) | (v << (32 - a));
               c = r[31];
            end
         end
      endcase
      return {c, r};
   endfunction

   function automatic rsp_type predict_alu(req_type q);
      opcode_type  op;
      logic [31:0] op2;
      logic [31:0] res;
      logic        c;
      logic [7:0]  amt;
      rsp_type     p;
      op = opcode_type'(q.instr[24:21]);
      if (q.instr[25]) begin
         {c, op2} = barrel_shift(SH_ROR, {24'd0, q.instr[7:0]},
                                 {3'd0, q.instr[11:8], 1'b0}, q.carry_in);
      end else begin
         amt = q.instr[4] ? q.rs_value[7:0] : {3'd0, q.instr[11:7]};
         {c, op2} = barrel_shift(shift_kind_type'(q.instr[6:5]), q.rm_value, amt,
                                 q.carry_in);
      end
      p.write_back     = 1'b1;
      p.invalid_opcode = 1'b0;
      case (op)
         OP_AND: res = q.rn_value & op2;
         OP_EOR: res = q.rn_value ^ op2;
         OP_ORR: res = q.rn_value | op2;
         OP_MOV: res = op2;
         OP_TST: begin
            res = q.rn_value & op2;
            p.write_back = 1'b0;
         end
         OP_TEQ: begin
            res = q.rn_value ^ op2;
            p.write_back = 1'b0;
         end
         OP_SUB: begin
            res = q.rn_value - op2;
            c   = (q.rn_value >= op2);
         end
         OP_CMP: begin
            res = q.rn_value - op2;
            c   = (q.rn_value >= op2);
            p.write_back = 1'b0;
         end
         OP_RSB: begin
            res = op2 - q.rn_value;
            c   = (op2 >= q.rn_value);
         end
         OP_ADD: {c, res} = {1'b0, q.rn_value} + {1'b0, op2};
         default: begin
            res = q.rn_value;
            p.invalid_opcode = 1'b1;
         end
      endcase
      p.result       = res;
      p.dest_index   = q.instr[15:12];
      p.flags_update = q.instr[20];
      p.neg_flag     = q.instr[20] & res[31];
      p.zero_flag    = q.instr[20] & (res == 32'd0);
      p.carry_out    = q.instr[20] ? c : q.carry_in;
      return p;
   endfunction

   function automatic string format_rsp(rsp_type r);
      return $sformatf("result=%h rd=%h wb=%b s=%b n=%b z=%b c=%b inv=%b", r.result,
                       r.dest_index, r.write_back, r.flags_update, r.neg_flag,
                       r.zero_flag, r.carry_out, r.invalid_opcode);
   endfunction

   // Register operand 2: Rn is r1, Rm is r3, Rs is r2.
   function automatic logic [31:0] dp_reg(opcode_type op, logic s, logic [3:0] rd,
                                          shift_kind_type kind, logic by_reg,
                                          logic [4:0] amt);
      logic [31:0] w;
      w = 32'hE000_0000;
      w[24:21] = op;
      w[20]    = s;
      w[19:16] = 4'd1;
      w[15:12] = rd;
      if (by_reg) w[11:7] = {4'd2, 1'b0};
      else w[11:7] = amt;
      w[6:5] = kind;
      w[4]   = by_reg;
      w[3:0] = 4'd3;
      return w;
   endfunction

   function automatic logic [31:0] dp_imm(opcode_type op, logic s, logic [3:0] rd,
                                          logic [3:0] rot, logic [7:0] imm8);
      logic [31:0] w;
      w = 32'hE200_0000;
      w[24:21] = op;
      w[20]    = s;
      w[19:16] = 4'd1;
      w[15:12] = rd;
      w[11:8]  = rot;
      w[7:0]   = imm8;
      return w;
   endfunction

   task automatic add_req(logic [31:0] instr, logic [31:0] rn, logic [31:0] rm,
                          logic [31:0] rs, logic cin);
      req_type r;
      r.instr    = instr;
      r.rn_value = rn;
      r.rm_value = rm;
      r.rs_value = rs;
      r.carry_in = cin;
      pending_req.push_back(r);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic opcode_type pick_legal_op();
      case ($urandom_range(9))
         0: return OP_AND;
         1: return OP_EOR;
         2: return OP_SUB;
         3: return OP_RSB;
         4: return OP_ADD;
         5: return OP_TST;
         6: return OP_TEQ;
         7: return OP_CMP;
         8: return OP_ORR;
         default: return OP_MOV;
      endcase
   endfunction

   // Driver: presents queued requests, holding each one until it is taken.
   always @(posedge clock) begin
      req_type junk;
      logic    pause;
      junk.instr    = $urandom;
      junk.rn_value = $urandom;
      junk.rm_value = $urandom;
      junk.rs_value = $urandom;
      junk.carry_in = 1'($urandom_range(1));
      // A long stretch of back-to-back requests in the middle of the random part.
      pause = (sent_count < 300 || sent_count >= 450) && ($urandom_range(99) < 34);
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) sent_count++;
         if (pending_req.size() != 0 && !pause) begin
            req_item <= pending_req.pop_front();
            start    <= 1'b1;
         end else begin
            req_item <= junk;
            start    <= 1'b0;
         end
      end
   end

   // Monitor: predicts each accepted request and checks responses in order.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            expected_rsp.push_back(predict_alu(req_item));
            if (req_item.instr[20]) flags_set_count++;
            if (!req_item.instr[25] && req_item.instr[4]) reg_shift_count++;
            if (predict_alu(req_item).invalid_opcode) unsupported_count++;
         end
         if (rsp_strobe) begin
            checked_count++;
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding: %s", $realtime,
                           format_rsp(rsp_item));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_item.result !== want.result ||
                   rsp_item.dest_index !== want.dest_index ||
                   rsp_item.write_back !== want.write_back ||
                   rsp_item.flags_update !== want.flags_update ||
                   rsp_item.neg_flag !== want.neg_flag ||
                   rsp_item.zero_flag !== want.zero_flag ||
                   rsp_item.carry_out !== want.carry_out ||
                   rsp_item.invalid_opcode !== want.invalid_opcode) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch on response %0d", $realtime, checked_count);
                     $display("   expected %s", format_rsp(want));
                     $display("   actual   %s", format_rsp(rsp_item));
                  end
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] instr;
      logic [31:0] rn;
      logic [31:0] rm;
      logic [31:0] rs;
      int          wait_cycles;

      // Every opcode once, each with a zero shift so that the carry passes through.
      for (int k = 0; k < 16; k++) begin
         add_req(dp_reg(opcode_type'(4'(k)), (k % 4 != 3), 4'(k),
                        shift_kind_type'(k[3:2]), k[0], 5'd0),
                 (k % 3 == 0) ? 32'h0 : (k % 3 == 1) ? 32'hFFFF_FFFF : 32'h8000_0001,
                 k[1] ? 32'h8000_0000 : 32'h0000_0001, 32'hFFFF_FF00, 1'b1);
      end
      // Register shifts at and beyond the word width.
      add_req(dp_reg(OP_MOV, 1'b1, 4'd4, SH_LSL, 1'b1, 5'd0), 32'h0, 32'h1, 32'd32, 1'b0);
      add_req(dp_reg(OP_MOV, 1'b1, 4'd5, SH_LSR, 1'b1, 5'd0), 32'h0, 32'h8000_0000,
              32'd32, 1'b0);
      add_req(dp_reg(OP_MOV, 1'b1, 4'd6, SH_LSL, 1'b1, 5'd0), 32'h0, 32'hFFFF_FFFF,
              32'd33, 1'b1);
      add_req(dp_reg(OP_MOV, 1'b1, 4'd7, SH_ASR, 1'b1, 5'd0), 32'h0, 32'h8000_0000,
              32'd40, 1'b0);
      add_req(dp_reg(OP_MOV, 1'b1, 4'd8, SH_ROR, 1'b1, 5'd0), 32'h0, 32'h8000_0001,
              32'd64, 1'b0);
      // Immediates with no rotation and with the largest rotation.
      add_req(dp_imm(OP_MOV, 1'b1, 4'd9, 4'd0, 8'hFF), 32'h0, 32'h0, 32'h0, 1'b1);
      add_req(dp_imm(OP_ADD, 1'b1, 4'd10, 4'd15, 8'hFF), 32'h1234_5678, 32'h0, 32'h0, 1'b0);
      // Equal compare, add with carry out and a reverse subtract that borrows.
      add_req(dp_reg(OP_CMP, 1'b1, 4'd11, SH_LSL, 1'b0, 5'd0), 32'h1234_5678,
              32'h1234_5678, 32'h0, 1'b0);
      add_req(dp_imm(OP_ADD, 1'b1, 4'd12, 4'd0, 8'h01), 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
      add_req(dp_reg(OP_RSB, 1'b1, 4'd13, SH_ASR, 1'b0, 5'd31), 32'h0000_0010,
              32'h4000_0000, 32'h0, 1'b1);

      for (int n = 0; n < 800; n++) begin
         instr = $urandom;
         rn    = pick_word();
         rm    = pick_word();
         rs    = $urandom;
         if ($urandom_range(4) != 0) instr[24:21] = pick_legal_op();
         case ($urandom_range(5))
            0: rs[7:0] = 8'd0;
            1: rs[7:0] = 8'd32;
            2: rs[7:0] = 8'(32 * $urandom_range(2, 7));
            3: rs[7:0] = 8'($urandom_range(33, 255));
            default: rs[7:0] = 8'($urandom_range(1, 31));
         endcase
         // Now and then make operand 2 equal to Rn so that zero results turn up.
         if ($urandom_range(7) == 0) begin
            instr[25]   = 1'b0;
            instr[11:4] = 8'd0;
            rm          = rn;
         end
         add_req(instr, rn, rm, rs, 1'($urandom_range(1)));
      end
      total_requests = pending_req.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_requests) @(negedge clock);
      wait_cycles = 0;
      while (expected_rsp.size() != 0 && wait_cycles < 100) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(negedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0d requests never produced a response", expected_rsp.size());
         mismatch_count += expected_rsp.size();
      end

      $display("Checked %0d responses to %0d requests, %0d of them failing.",
               checked_count, total_requests, mismatch_count);
      $display("Requests with flags update: %0d, unsupported opcodes: %0d, %s %0d.",
               flags_set_count, unsupported_count, "shifts by register:", reg_shift_count);
      if (mismatch_count == 0) begin
         $display("PASS data_processing_alu");
      end else begin
         $display("FAIL data_processing_alu");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d of %0d requests sent.", sent_count, total_requests);
      $display("FAIL data_processing_alu");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dpa_pkg.sv
rtl/core/dpa_decode.sv
rtl/core/dpa_shift.sv
rtl/core/dpa_alu.sv
rtl/core/data_processing_alu.sv
tb/testbench.sv
